// ===== design/assert_macros.svh =====
// Assertion macros used by the controller design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pidc_pkg.sv =====
// Package: widths, register indexes and limit codes of the clamped PID controller.
`default_nettype none
package pidc_pkg;

  // Integral accumulator width and gain fraction bits
  localparam int INTEGRAL_WIDTH = 32;
  localparam int GAIN_FRAC_BITS = 8;

  // Field widths
  localparam int DATA_W = 16;
  localparam int GAIN_W = 16;
  localparam int ERR_W  = DATA_W + 1;

  // Term widths: unsigned gain (zero-extended by one bit) times signed operand
  localparam int TP_W  = GAIN_W + 1 + ERR_W;
  localparam int TI_W  = GAIN_W + 1 + INTEGRAL_WIDTH;
  localparam int DIF_W = ERR_W + 1;
  localparam int TD_W  = GAIN_W + 1 + DIF_W;
  localparam int SUM_W = TI_W + 2;

  // Configuration port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_DRIVE_MIN  = 3'd3,
    CFG_DRIVE_MAX  = 3'd4
  } cfg_idx_t;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd1280;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd768;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd512;
  localparam logic [DATA_W-1:0] DRIVE_MIN_RST  = 16'd0;
  localparam logic [DATA_W-1:0] DRIVE_MAX_RST  = 16'hFFFF;

  // Integral value after reset and after a high clamp
  localparam logic signed [INTEGRAL_WIDTH-1:0] INTEG_RESTART = INTEGRAL_WIDTH'(1);

  // Limit status reported with each drive value
  typedef enum logic [1:0] {
    LIMIT_NONE = 2'd0,
    LIMIT_HIGH = 2'd1,
    LIMIT_LOW  = 2'd2
  } limit_t;

endpackage
`default_nettype wire

// ===== design/pid_controller_clamped.sv =====
// Clamped PID controller with integral anti-windup: one drive value per sample.
// Each input beat (setpoint, measured) produces exactly one output beat (drive,
// limit status). The block takes one beat per clock cycle when the output side
// keeps up. A beat accepted into the input register passes through the
// error/integral/multiply/sum/clamp path into the result register, which drives
// out_tvalid. While a result is stalled the input register holds its beat and
// in_tready falls. That combinational path also closes the feedback on the
// previous error and the integral, which is what allows the next sample to enter
// the input register as the current one moves to the result register.
// Gains are unsigned Q8.8, limits are integers; the integral saturates to a
// signed 32-bit range and restarts at one after a high clamp. Configuration
// writes are taken at any time (cfg_ready is always high) but are intended while
// the block is idle.
`default_nettype none
`include "assert_macros.svh"

module pid_controller_clamped (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] setpoint, [31:16] measured
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] drive
  output logic [1:0]       out_tuser,  // [1:0] limit_hit
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = pidc_pkg::INTEGRAL_WIDTH;
  localparam int FB = pidc_pkg::GAIN_FRAC_BITS;
  localparam int DW = pidc_pkg::DATA_W;

  // configuration registers
  logic [pidc_pkg::GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [DW-1:0]               drive_min_r, drive_max_r;

  // input stage
  logic          in_valid_r;
  logic [DW-1:0] setpoint_r, measured_r;

  // loop state
  logic signed [pidc_pkg::ERR_W-1:0] prev_err_r;
  logic signed [IW-1:0]              integ_r;
  logic signed [pidc_pkg::ERR_W-1:0] prev_err_nxt;
  logic signed [IW-1:0]              integ_nxt;

  // result stage
  logic                out_valid_r;
  logic [DW-1:0]       drive_r, drive_nxt;
  pidc_pkg::limit_t    limit_r, limit_nxt;

  // datapath
  logic                               fire;
  logic signed [pidc_pkg::ERR_W-1:0]  err;
  logic signed [IW:0]                 cand_wide;
  logic signed [IW-1:0]               cand;
  logic signed [pidc_pkg::DIF_W-1:0]  dif;
  logic signed [pidc_pkg::TP_W-1:0]   tp;
  logic signed [pidc_pkg::TI_W-1:0]   ti;
  logic signed [pidc_pkg::TD_W-1:0]   td;
  logic signed [pidc_pkg::SUM_W-1:0]  drv, lim_lo, lim_hi;

  // handshake: the input register moves on when the result register is free
  assign fire       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || fire;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive_r;
  assign out_tuser  = limit_r;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= pidc_pkg::PROP_GAIN_RST;
      integ_gain_r <= pidc_pkg::INTEG_GAIN_RST;
      deriv_gain_r <= pidc_pkg::DERIV_GAIN_RST;
      drive_min_r  <= pidc_pkg::DRIVE_MIN_RST;
      drive_max_r  <= pidc_pkg::DRIVE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (pidc_pkg::cfg_idx_t'(cfg_index))
        pidc_pkg::CFG_PROP_GAIN:  prop_gain_r  <= cfg_data;
        pidc_pkg::CFG_INTEG_GAIN: integ_gain_r <= cfg_data;
        pidc_pkg::CFG_DERIV_GAIN: deriv_gain_r <= cfg_data;
        pidc_pkg::CFG_DRIVE_MIN:  drive_min_r  <= cfg_data;
        pidc_pkg::CFG_DRIVE_MAX:  drive_max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      setpoint_r <= in_tdata[15:0];
      measured_r <= in_tdata[31:16];
    end
  end

  // error and saturated candidate integral
  always_comb begin
    err       = $signed({1'b0, setpoint_r}) - $signed({1'b0, measured_r});
    cand_wide = (IW + 1)'(integ_r) + (IW + 1)'(err);
    if (cand_wide[IW] != cand_wide[IW-1]) begin
      cand = {cand_wide[IW], {(IW - 1){~cand_wide[IW]}}};
    end else begin
      cand = cand_wide[IW-1:0];
    end
    dif = pidc_pkg::DIF_W'(prev_err_r) - pidc_pkg::DIF_W'(err);
  end

  // three gain products and their sum, in Q.FB
  always_comb begin
    tp  = $signed({1'b0, prop_gain_r}) * err;
    ti  = $signed({1'b0, integ_gain_r}) * cand;
    td  = $signed({1'b0, deriv_gain_r}) * dif;
    drv = pidc_pkg::SUM_W'(tp) + pidc_pkg::SUM_W'(ti) + pidc_pkg::SUM_W'(td);
    lim_lo = $signed(pidc_pkg::SUM_W'(drive_min_r) << FB);
    lim_hi = $signed(pidc_pkg::SUM_W'(drive_max_r) << FB);
  end

  // clamp and anti-windup decision; high test ahead of low test
  always_comb begin
    prev_err_nxt = err;
    integ_nxt    = integ_r;
    drive_nxt    = drive_min_r;
    limit_nxt    = pidc_pkg::LIMIT_NONE;
    if (drv < lim_hi && drv > lim_lo) begin
      integ_nxt = cand;
      drive_nxt = drv[FB +: DW];
    end else if (drv > lim_hi) begin
      integ_nxt = pidc_pkg::INTEG_RESTART;
      drive_nxt = drive_max_r;
      limit_nxt = pidc_pkg::LIMIT_HIGH;
    end else if (drv < lim_lo) begin
      limit_nxt = pidc_pkg::LIMIT_LOW;
    end else if (drv == lim_hi) begin
      drive_nxt = drive_max_r;
    end
  end

  // loop state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= pidc_pkg::INTEG_RESTART;
    end else if (fire) begin
      prev_err_r <= prev_err_nxt;
      integ_r    <= integ_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r <= drive_nxt;
      limit_r <= limit_nxt;
    end
  end

  // checks
  `ASSERT_NEXT(a_fire_out, clk, rst_n, fire, out_valid_r,
    "result register not loaded after a sample was processed")
  `ASSERT_NEXT(a_high_restart, clk, rst_n, fire && limit_nxt == pidc_pkg::LIMIT_HIGH,
    integ_r == pidc_pkg::INTEG_RESTART, "integral not restarted after a high clamp")
  `ASSERT_NEXT(a_prev_err, clk, rst_n, fire, prev_err_r == $past(err),
    "previous error not taken from the processed sample")
  `ASSERT_SAME(a_hold_stall, clk, rst_n, out_valid_r && !out_tready, !fire,
    "new sample processed while the result register is stalled")

endmodule
`default_nettype wire

// ===== bench/pid_drive_checker.sv =====
`timescale 1ns / 100ps
// Checker for the clamped PID controller: predicts every drive beat and compares it.
module pid_drive_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic [pidc_pkg::DATA_W-1:0] drive;
    pidc_pkg::limit_t            limit;
  } drive_beat_t;

  // Shadow registers and controller state
  logic [pidc_pkg::GAIN_W-1:0] kp, ki, kd;
  logic [pidc_pkg::DATA_W-1:0] lim_lo, lim_hi;
  longint                      err_last;
  longint                      integ_acc;

  drive_beat_t drive_expected_q[$];

  // One control step: returns the drive beat and advances error and integral
  function automatic drive_beat_t predict_drive(input logic [pidc_pkg::DATA_W-1:0] sp,
                                                input logic [pidc_pkg::DATA_W-1:0] mv);
    drive_beat_t r;
    longint      e, cand, ihi, ilo, drv, lo, hi;
    e    = longint'({1'b0, sp}) - longint'({1'b0, mv});
    ihi  = (longint'(1) <<< (pidc_pkg::INTEGRAL_WIDTH - 1)) - 1;
    ilo  = -ihi - 1;
    cand = integ_acc + e;
    if (cand > ihi) cand = ihi;
    if (cand < ilo) cand = ilo;
    drv = longint'({1'b0, kp}) * e + longint'({1'b0, ki}) * cand
        + longint'({1'b0, kd}) * (err_last - e);
    lo  = longint'({1'b0, lim_lo}) <<< pidc_pkg::GAIN_FRAC_BITS;
    hi  = longint'({1'b0, lim_hi}) <<< pidc_pkg::GAIN_FRAC_BITS;
    // high test comes first, so misordered limits clamp high before low
    if (drv < hi && drv > lo) begin
      integ_acc = cand;
      r.drive   = pidc_pkg::DATA_W'(drv >>> pidc_pkg::GAIN_FRAC_BITS);
      r.limit   = pidc_pkg::LIMIT_NONE;
    end else if (drv > hi) begin
      integ_acc = pidc_pkg::INTEG_RESTART;
      r.drive   = lim_hi;
      r.limit   = pidc_pkg::LIMIT_HIGH;
    end else if (drv < lo) begin
      r.drive = lim_lo;
      r.limit = pidc_pkg::LIMIT_LOW;
    end else begin
      r.drive = (drv == hi) ? lim_hi : lim_lo;
      r.limit = pidc_pkg::LIMIT_NONE;
    end
    err_last = e;
    return r;
  endfunction

  // One line per mismatch, and a count
  task automatic report_mismatch(input string msg);
    $display("%0t: drive check: %s", $time, msg);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    drive_beat_t got, want;
    if (!rst_n) begin
      kp        = pidc_pkg::PROP_GAIN_RST;
      ki        = pidc_pkg::INTEG_GAIN_RST;
      kd        = pidc_pkg::DERIV_GAIN_RST;
      lim_lo    = pidc_pkg::DRIVE_MIN_RST;
      lim_hi    = pidc_pkg::DRIVE_MAX_RST;
      err_last  = 0;
      integ_acc = pidc_pkg::INTEG_RESTART;
      drive_expected_q.delete();
    end else begin
      // register writes; unused indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pidc_pkg::CFG_PROP_GAIN:  kp     = cfg_data;
          pidc_pkg::CFG_INTEG_GAIN: ki     = cfg_data;
          pidc_pkg::CFG_DERIV_GAIN: kd     = cfg_data;
          pidc_pkg::CFG_DRIVE_MIN:  lim_lo = cfg_data;
          pidc_pkg::CFG_DRIVE_MAX:  lim_hi = cfg_data;
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.drive = out_tdata;
        got.limit = pidc_pkg::limit_t'(out_tuser);
        if (drive_expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat with no sample pending (drive %0d)",
                                    got.drive));
        end else begin
          want = drive_expected_q.pop_front();
          if (got.drive !== want.drive)
            report_mismatch($sformatf("drive %0d, expected %0d", got.drive, want.drive));
          if (got.limit !== want.limit)
            report_mismatch($sformatf("limit_hit %0d, expected %0d", got.limit,
                                      want.limit));
        end
      end
      // sample beat: [15:0] setpoint, [31:16] measured
      if (in_tvalid && in_tready)
        drive_expected_q.push_back(predict_drive(in_tdata[15:0], in_tdata[31:16]));
    end
    pending <= drive_expected_q.size();
  end

endmodule

// ===== bench/tb_pid_controller_clamped.sv =====
`timescale 1ns / 100ps
// Testbench top for the clamped PID controller: clock, reset, stimulus and verdict.
module tb_pid_controller_clamped;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam logic [2:0]  CFG_SPARE      = 3'd7;   // index with no register behind it

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [15:0] setpoint, [31:16] measured
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [15:0] drive
  logic [1:0]  out_tuser;   // [1:0] limit_hit
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int pending;
  int send_idle_pct = 18;
  int recv_idle_pct = 59;
  int quiet_cycles  = 0;

  pid_controller_clamped dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pid_drive_checker drive_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  initial out_tready = 1'b0;
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (rst_n)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL pid_controller_clamped");
      $finish;
    end
  end

  // One sample beat, with random idle cycles ahead of it
  task automatic push_sample(input logic [15:0] sp, input logic [15:0] mv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {mv, sp};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off the sender until every drive beat is back
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write beat; valid is left high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] p, input logic [15:0] i,
                               input logic [15:0] d, input logic [15:0] mn,
                               input logic [15:0] mx);
    wait_drained();
    write_reg(pidc_pkg::CFG_PROP_GAIN, p);
    write_reg(pidc_pkg::CFG_INTEG_GAIN, i);
    write_reg(pidc_pkg::CFG_DERIV_GAIN, d);
    write_reg(pidc_pkg::CFG_DRIVE_MIN, mn);
    write_reg(pidc_pkg::CFG_DRIVE_MAX, mx);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 1024));
    endcase
  endfunction

  // Random gains and limits, extremes and misordered limits included
  task automatic random_settings();
    logic [15:0] mn, mx;
    case ($urandom_range(7))
      0: begin
        mn = 16'h0000;
        mx = 16'hFFFF;
      end
      1: begin
        mn = 16'($urandom_range(0, 1000));
        mx = mn + 16'($urandom_range(100, 20000));
      end
      2: begin
        mn = 16'($urandom);
        mx = 16'($urandom);
      end
      3: begin
        mn = 16'($urandom);
        mx = mn;
      end
      default: begin
        mn = 16'($urandom_range(0, 200));
        mx = 16'($urandom_range(5000, 65535));
      end
    endcase
    load_settings(pick_gain(), pick_gain(), pick_gain(), mn, mx);
  endtask

  // Mostly small errors so the drive lands between the limits now and then
  task automatic random_sample(output logic [15:0] sp, output logic [15:0] mv);
    int m;
    sp = 16'($urandom);
    case ($urandom_range(9))
      0: mv = 16'($urandom);
      1: mv = sp;
      2: begin
        sp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        mv = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        m = int'(sp) + $urandom_range(0, 600) - 300;
        if (m < 0) m = 0;
        if (m > 65535) m = 65535;
        mv = 16'(m);
      end
    endcase
  endtask

  initial begin
    logic [15:0] sp, mv;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings; a write to an unused index must change nothing
    write_reg(CFG_SPARE, 16'hFFFF);
    cfg_valid = 1'b0;
    push_sample(16'h0000, 16'h0000);
    push_sample(16'hFFFF, 16'h0000);
    push_sample(16'h0000, 16'hFFFF);
    push_sample(16'hFFFF, 16'hFFFF);
    push_sample(16'h5555, 16'hAAAA);
    push_sample(16'hAAAA, 16'h5555);

    // Unit proportional gain: on each limit, between, above, below
    load_settings(16'd256, 16'd0, 16'd0, 16'd0, 16'd100);
    push_sample(16'd100, 16'd0);
    push_sample(16'd0, 16'd0);
    push_sample(16'd50, 16'd0);
    push_sample(16'd101, 16'd0);
    push_sample(16'd0, 16'd1);

    // Limits the wrong way round, then both limits equal
    load_settings(16'd256, 16'd0, 16'd0, 16'd200, 16'd100);
    push_sample(16'd150, 16'd0);
    push_sample(16'd50, 16'd0);
    load_settings(16'd256, 16'd0, 16'd0, 16'd100, 16'd100);
    push_sample(16'd100, 16'd0);
    push_sample(16'd99, 16'd0);

    // Largest gains
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    push_sample(16'hFFFF, 16'h0000);
    push_sample(16'h0000, 16'hFFFF);
    push_sample(16'h0001, 16'h0000);

    // high clamp brings the integral back to its restart value
    load_settings(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    push_sample(16'hFFFF, 16'h0000);

    // Random part over three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 5; s++) begin
        random_settings();
        for (int n = 0; n < 84; n++) begin
          random_sample(sp, mv);
          push_sample(sp, mv);
          if ($urandom_range(199) == 0) wait_drained();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS pid_controller_clamped");
    else
      $display("FAIL pid_controller_clamped");
    $finish;
  end

endmodule
